FILE: sv/goc_pkg.sv
// Shared widths, constants and types of the gradient orientation cost unit.
package goc_pkg;

   // Width of one signed gradient component and fraction bits of a magnitude.
   localparam int GRAD_WIDTH = 13;
   localparam int FRAC_BITS  = 8;
   // Fraction bits of the orientation ratio and weight (Q1.16).
   localparam int RATIO_BITS = 16;
   localparam int COST_WIDTH = 21;

   // A magnitude is below 2^GRAD_WIDTH in the integer part.
   localparam int MAG_W  = GRAD_WIDTH + FRAC_BITS;
   // Radicand of the square root: sum of squares scaled by 2^(2*FRAC_BITS).
   localparam int RAD_W  = 2 * MAG_W;
   localparam int SQ_W   = 2 * GRAD_WIDTH;
   localparam int DOT_W  = 2 * GRAD_WIDTH;
   // Dividend of the first division: |dot| scaled by 2^(FRAC_BITS+RATIO_BITS).
   localparam int NUM_W  = DOT_W + FRAC_BITS + RATIO_BITS;
   // Quotient bits; both quotients are known to stay below 2^QUO_W.
   localparam int QUO_W  = GRAD_WIDTH + RATIO_BITS + 1;
   localparam int RAT_W  = RATIO_BITS + 1;
   localparam int SIDE_W = 2 * MAG_W;

   localparam logic [MAG_W-1:0] MAG_ONE   = MAG_W'(1) << FRAC_BITS;
   localparam logic [RAT_W-1:0] RATIO_ONE = RAT_W'(1) << RATIO_BITS;
   localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

   // Valid bit and the data that travels alongside an arithmetic pipeline.
   typedef struct packed {
      logic              valid;
      logic [SIDE_W-1:0] side;
   } lane_type;

endpackage

FILE: sv/goc_sqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module goc_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  goc_pkg::lane_type           in_lane,
   input  logic [goc_pkg::RAD_W-1:0]   in_rad,
   output goc_pkg::lane_type           out_lane,
   output logic [goc_pkg::MAG_W-1:0]   out_root
);
   import goc_pkg::*;

   logic [MAG_W:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [MAG_W+1];
   logic [MAG_W-1:0]  root_ff [MAG_W+1];
   logic [MAG_W+1:0]  rem_ff  [MAG_W];
   logic [RAD_W-1:0]  rad_ff  [MAG_W];
   logic [MAG_W-1:0]  root_in [MAG_W];
   logic [MAG_W+1:0]  rem_in  [MAG_W];

   always_comb begin
      logic [MAG_W+3:0] shifted;
      logic [MAG_W+3:0] trial;
      for (int k = 0; k < MAG_W; k++) begin
         shifted = {rem_ff[k], rad_ff[k][RAD_W-1 -: 2]};
         trial   = {2'b00, root_ff[k], 2'b01};
         if (shifted >= trial) begin
            rem_in[k]  = (MAG_W+2)'(shifted - trial);
            root_in[k] = {root_ff[k][MAG_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = shifted[MAG_W+1:0];
            root_in[k] = {root_ff[k][MAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[MAG_W-1:0], in_lane.valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_lane.side;
      root_ff[0] <= '0;
      rem_ff[0]  <= '0;
      rad_ff[0]  <= in_rad;
      for (int k = 0; k < MAG_W; k++) begin
         side_ff[k+1] <= side_ff[k];
         root_ff[k+1] <= root_in[k];
      end
      for (int k = 0; k < MAG_W-1; k++) begin
         rem_ff[k+1] <= rem_in[k];
         rad_ff[k+1] <= {rad_ff[k][RAD_W-3:0], 2'b00};
      end
   end

   assign out_lane.valid = vld_ff[MAG_W];
   assign out_lane.side  = side_ff[MAG_W];
   assign out_root       = root_ff[MAG_W];

endmodule

FILE: sv/goc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module goc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  goc_pkg::lane_type           in_lane,
   input  logic [goc_pkg::NUM_W-1:0]   in_num,
   input  logic [goc_pkg::MAG_W-1:0]   in_den,
   output goc_pkg::lane_type           out_lane,
   output logic [goc_pkg::QUO_W-1:0]   out_quo
);
   import goc_pkg::*;

   logic [QUO_W:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [QUO_W+1];
   logic [QUO_W-1:0]  low_ff  [QUO_W+1];
   logic [MAG_W-1:0]  den_ff  [QUO_W];
   logic [MAG_W-1:0]  rem_ff  [QUO_W];
   logic [MAG_W-1:0]  rem_in  [QUO_W];
   logic [QUO_W-1:0]  low_in  [QUO_W];

   // The low word holds the unused dividend bits at the top and the
   // quotient bits gathered so far at the bottom.
   always_comb begin
      logic [MAG_W:0] trial;
      for (int k = 0; k < QUO_W; k++) begin
         trial = {rem_ff[k], low_ff[k][QUO_W-1]};
         if (trial >= {1'b0, den_ff[k]}) begin
            rem_in[k] = MAG_W'(trial - {1'b0, den_ff[k]});
            low_in[k] = {low_ff[k][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[MAG_W-1:0];
            low_in[k] = {low_ff[k][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QUO_W-1:0], in_lane.valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_lane.side;
      den_ff[0]  <= in_den;
      rem_ff[0]  <= {1'b0, in_num[NUM_W-1:QUO_W]};
      low_ff[0]  <= in_num[QUO_W-1:0];
      for (int k = 0; k < QUO_W; k++) begin
         side_ff[k+1] <= side_ff[k];
         low_ff[k+1]  <= low_in[k];
      end
      for (int k = 0; k < QUO_W-1; k++) begin
         den_ff[k+1] <= den_ff[k];
         rem_ff[k+1] <= rem_in[k];
      end
   end

   assign out_lane.valid = vld_ff[QUO_W];
   assign out_lane.side  = side_ff[QUO_W];
   assign out_quo        = low_ff[QUO_W];

endmodule

FILE: sv/gradient_orientation_cost_unit.sv
// Top level of the gradient orientation cost unit: products, roots, divisions, weighting.
//
//   channel   ports                                  direction  handshake
//   request   start, busy, req_base_grad_x/_y,       in         start && !busy
//             req_match_grad_x/_y
//   result    rsp_valid, rsp_cost                    out        rsp_valid, one cycle
//
// One request is taken on every clock; busy stays low once reset is over.
// A result passes through three product/sum stages, the 22-stage square root,
// two 31-stage dividers and four weighting stages.
// Reset clears the valid bits and raises busy; data registers are left as they are.
// The receiver cannot stall, so the pipeline never holds and no request waits.
module gradient_orientation_cost_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [goc_pkg::GRAD_WIDTH-1:0] req_base_grad_x,
   input  logic signed [goc_pkg::GRAD_WIDTH-1:0] req_base_grad_y,
   input  logic signed [goc_pkg::GRAD_WIDTH-1:0] req_match_grad_x,
   input  logic signed [goc_pkg::GRAD_WIDTH-1:0] req_match_grad_y,
   output logic                                 rsp_valid,
   output logic [goc_pkg::COST_WIDTH-1:0]       rsp_cost
);
   import goc_pkg::*;

   localparam int DIV2_PAD = NUM_W - QUO_W - FRAC_BITS;
   localparam int SH_W     = MAG_W + 1;
   localparam int EXT_W    = SH_W + COST_WIDTH;

   // The busy flag is held high through reset and drops once reset is over.
   logic busy_ff;

   // Stage one: the request is registered.
   logic                         v1_ff;
   logic signed [GRAD_WIDTH-1:0] bx_ff, by_ff, mx_ff, my_ff;
   // Stage two: squares and cross products.
   logic                         v2_ff;
   logic signed [2*GRAD_WIDTH-1:0] bxx_ff, byy_ff, mxx_ff, myy_ff, dx_ff, dy_ff;
   // Stage three: sums of squares and the dot product.
   logic                         v3_ff;
   logic [SQ_W-1:0]              sum_b_ff, sum_m_ff;
   logic signed [DOT_W:0]        dot_ff;
   logic [DOT_W-1:0]             adot;

   // Square roots give the magnitudes; the base pipeline carries |dot| along.
   lane_type                     sqb_in_lane, sqm_in_lane, sqb_out_lane, sqm_out_lane;
   logic [MAG_W-1:0]             mb_raw, mm_raw, mb, mm, mn;

   // First division gives t, the second gives the ratio r.
   lane_type                     d1_in_lane, d1_out_lane, d2_in_lane, d2_out_lane;
   logic [QUO_W-1:0]             t_quo, r_quo;
   logic [MAG_W-1:0]             d1_mb, d1_mm;

   // Weighting stages.
   logic                         va_ff, vb_ff, vc_ff, vd_ff;
   logic [RAT_W-1:0]             ra_ff, w_ff;
   logic [RAT_W-1:0]             ra_in;
   logic [MAG_W-1:0]             mna_ff, mnb_ff;
   logic [2*RAT_W-1:0]           rr;
   logic [RAT_W+MAG_W-1:0]       cp_ff;
   logic [SH_W-1:0]              sh;
   logic [EXT_W-1:0]             ext;
   logic [COST_WIDTH-1:0]        cost_ff, cost_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         vd_ff   <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         v1_ff   <= start && !busy_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         va_ff   <= d2_out_lane.valid;
         vb_ff   <= va_ff;
         vc_ff   <= vb_ff;
         vd_ff   <= vc_ff;
      end
   end

   assign busy = busy_ff;

   // Front end: register the request, then multiply, then add.
   always_ff @(posedge clock) begin
      bx_ff    <= req_base_grad_x;
      by_ff    <= req_base_grad_y;
      mx_ff    <= req_match_grad_x;
      my_ff    <= req_match_grad_y;
      bxx_ff   <= bx_ff * bx_ff;
      byy_ff   <= by_ff * by_ff;
      mxx_ff   <= mx_ff * mx_ff;
      myy_ff   <= my_ff * my_ff;
      dx_ff    <= bx_ff * mx_ff;
      dy_ff    <= by_ff * my_ff;
      // Squares are never negative and their sum stays below 2^SQ_W.
      sum_b_ff <= $unsigned(bxx_ff) + $unsigned(byy_ff);
      sum_m_ff <= $unsigned(mxx_ff) + $unsigned(myy_ff);
      dot_ff   <= (DOT_W+1)'(dx_ff) + (DOT_W+1)'(dy_ff);
   end

   // The sign of the dot product is lost in the square, so only |dot| travels.
   assign adot = dot_ff[DOT_W] ? DOT_W'(-dot_ff) : dot_ff[DOT_W-1:0];

   assign sqb_in_lane.valid = v3_ff;
   assign sqb_in_lane.side  = SIDE_W'(adot);
   assign sqm_in_lane.valid = v3_ff;
   assign sqm_in_lane.side  = '0;

   goc_sqrt u_sqrt_base (
      .clock    (clock),
      .reset    (reset),
      .in_lane  (sqb_in_lane),
      .in_rad   ({sum_b_ff, {(2*FRAC_BITS){1'b0}}}),
      .out_lane (sqb_out_lane),
      .out_root (mb_raw)
   );

   goc_sqrt u_sqrt_match (
      .clock    (clock),
      .reset    (reset),
      .in_lane  (sqm_in_lane),
      .in_rad   ({sum_m_ff, {(2*FRAC_BITS){1'b0}}}),
      .out_lane (sqm_out_lane),
      .out_root (mm_raw)
   );

   // Magnitudes are raised to 1.0 so that neither division sees a zero divisor.
   assign mb = (mb_raw < MAG_ONE) ? MAG_ONE : mb_raw;
   assign mm = (mm_raw < MAG_ONE) ? MAG_ONE : mm_raw;

   assign d1_in_lane.valid = sqb_out_lane.valid;
   assign d1_in_lane.side  = {mb, mm};

   goc_divider u_div_base (
      .clock    (clock),
      .reset    (reset),
      .in_lane  (d1_in_lane),
      .in_num   ({sqb_out_lane.side[DOT_W-1:0], {(FRAC_BITS+RATIO_BITS){1'b0}}}),
      .in_den   (mb),
      .out_lane (d1_out_lane),
      .out_quo  (t_quo)
   );

   assign d1_mb = d1_out_lane.side[SIDE_W-1 -: MAG_W];
   assign d1_mm = d1_out_lane.side[MAG_W-1:0];
   assign mn    = (d1_mb < d1_mm) ? d1_mb : d1_mm;

   assign d2_in_lane.valid = d1_out_lane.valid;
   assign d2_in_lane.side  = {mn, {MAG_W{1'b0}}};

   goc_divider u_div_match (
      .clock    (clock),
      .reset    (reset),
      .in_lane  (d2_in_lane),
      .in_num   ({{DIV2_PAD{1'b0}}, t_quo, {FRAC_BITS{1'b0}}}),
      .in_den   (d1_mm),
      .out_lane (d2_out_lane),
      .out_quo  (r_quo)
   );

   // Truncated magnitudes can lift the ratio just past 1.0; it saturates there.
   assign ra_in = (r_quo > QUO_W'(RATIO_ONE)) ? RATIO_ONE : r_quo[RAT_W-1:0];
   assign rr    = ra_ff * ra_ff;
   assign sh    = cp_ff[RATIO_BITS +: SH_W];
   assign ext   = EXT_W'(sh);

   always_comb begin
      if (ext > EXT_W'(COST_MAX)) begin
         cost_in = COST_MAX;
      end else begin
         cost_in = ext[COST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      ra_ff   <= ra_in;
      mna_ff  <= d2_out_lane.side[SIDE_W-1 -: MAG_W];
      w_ff    <= rr[RATIO_BITS +: RAT_W];
      mnb_ff  <= mna_ff;
      cp_ff   <= w_ff * mnb_ff;
      cost_ff <= cost_in;
   end

   assign rsp_valid = vd_ff;
   assign rsp_cost  = cost_ff;

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> v1_ff)
      else $error("accepted request did not enter the pipeline");

   a_roots_aligned: assert property (@(posedge clock) disable iff (reset)
      sqm_out_lane.valid == sqb_out_lane.valid)
      else $error("square root pipelines out of step");

   a_ratio_bounded: assert property (@(posedge clock) disable iff (reset)
      va_ff |-> (ra_ff <= RATIO_ONE))
      else $error("ratio above 1.0 after saturation");

   a_weight_bounded: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> (w_ff <= RATIO_ONE))
      else $error("orientation weight above 1.0");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vc_ff))
      else $error("result strobe without a request in the last stage");
`endif

endmodule

FILE: sim/tb.sv
// Testbench of the gradient orientation cost unit: driven requests, predicted and checked costs.
`timescale 1ns / 1ps

module tb;
   import goc_pkg::*;

   localparam int GW = GRAD_WIDTH;
   localparam int LATENCY = 91;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [GW-1:0] bx;
      logic signed [GW-1:0] by;
      logic signed [GW-1:0] mx;
      logic signed [GW-1:0] my;
   } grad_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [GW-1:0] req_base_grad_x = '0;
   logic signed [GW-1:0] req_base_grad_y = '0;
   logic signed [GW-1:0] req_match_grad_x = '0;
   logic signed [GW-1:0] req_match_grad_y = '0;
   logic rsp_valid;
   logic [COST_WIDTH-1:0] rsp_cost;

   grad_req_type pending_reqs[$];
   logic [COST_WIDTH-1:0] expected_costs[$];
   int idle_pct = 0;
   bit hold_sender = 1'b0;
   int mismatches = 0;
   int cycle_count = 0;

   gradient_orientation_cost_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_base_grad_x(req_base_grad_x), .req_base_grad_y(req_base_grad_y),
      .req_match_grad_x(req_match_grad_x), .req_match_grad_y(req_match_grad_y),
      .rsp_valid(rsp_valid), .rsp_cost(rsp_cost)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bitwise integer square root, floor of the exact root.
   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Magnitude in fixed point with FRAC_BITS fraction bits, raised to at least one.
   function automatic longint unsigned grad_magnitude(longint gx, longint gy);
      longint unsigned m;
      m = isqrt(longint'(gx * gx + gy * gy) << (2 * FRAC_BITS));
      return (m < (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : m;
   endfunction

   function automatic logic [COST_WIDTH-1:0] orientation_cost(grad_req_type r);
      longint bx, by, mx, my, dot;
      longint unsigned mb, mm, adot, t, q, w, mn, c;
      bx = r.bx; by = r.by; mx = r.mx; my = r.my;
      mb = grad_magnitude(bx, by);
      mm = grad_magnitude(mx, my);
      dot = bx * mx + by * my;
      adot = dot < 0 ? -dot : dot;
      t = (adot << (FRAC_BITS + RATIO_BITS)) / mb;
      q = (t << FRAC_BITS) / mm;
      if (q > (64'd1 << RATIO_BITS)) q = 64'd1 << RATIO_BITS;
      w = (q * q) >> RATIO_BITS;
      mn = mb < mm ? mb : mm;
      c = (w * mn) >> RATIO_BITS;
      if (c > 64'((1 << COST_WIDTH) - 1)) c = (1 << COST_WIDTH) - 1;
      return c[COST_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("error at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // Draws one gradient component: mostly full range, sometimes edges or small values.
   function automatic logic signed [GW-1:0] rand_grad();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return GW'($urandom);
      if (sel < 7) return GW'($signed($urandom_range(0, 8)) - 4);
      if (sel == 7) return {1'b1, {(GW-1){1'b0}}};
      if (sel == 8) return GW'(4080);
      return GW'(-4080);
   endfunction

   // Driver: offers the next pending request, keeping start high across back-to-back requests.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) void'(pending_reqs.pop_front());
         if ((!start || !busy) && pending_reqs.size() != 0 && !hold_sender &&
             $urandom_range(0, 99) >= idle_pct) begin
            start <= 1'b1;
            req_base_grad_x <= pending_reqs[0].bx;
            req_base_grad_y <= pending_reqs[0].by;
            req_match_grad_x <= pending_reqs[0].mx;
            req_match_grad_y <= pending_reqs[0].my;
            expected_costs.push_back(orientation_cost(pending_reqs[0]));
         end else if (start && !busy) begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: each strobed cost is compared with the oldest predicted one.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_costs.size() == 0) begin
            report_mismatch("cost with no request outstanding");
         end else begin
            if (rsp_cost !== expected_costs[0])
               report_mismatch($sformatf("cost %0d, predicted %0d",
                                         rsp_cost, expected_costs[0]));
            void'(expected_costs.pop_front());
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout");
         $display("gradient_orientation_cost_unit: mismatch");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || start) @(posedge clock);
      while (expected_costs.size() != 0) @(posedge clock);
   endtask

   task automatic add_req(int bx, int by, int mx, int my);
      grad_req_type r;
      r.bx = GW'(bx); r.by = GW'(by); r.mx = GW'(mx); r.my = GW'(my);
      pending_reqs.push_back(r);
   endtask

   initial begin
      int pcts[4];
      grad_req_type r;
      pcts = '{0, 86, 0, 7};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero gradients, extremes, the most negative code, parallel
      // and perpendicular vectors, and costs that saturate the ratio.
      add_req(0, 0, 0, 0);
      add_req(0, 0, 4080, 4080);
      add_req(4080, 4080, 4080, 4080);
      add_req(-4080, -4080, -4080, -4080);
      add_req(-4096, -4096, -4096, -4096);
      add_req(-4096, 0, 4080, 0);
      add_req(4080, -4080, 4080, 4080);
      add_req(1, 0, 0, 1);
      add_req(1, 1, 1, 1);
      add_req(3, 4, 3, 4);
      add_req(3, 4, -3, -4);
      add_req(1, 0, 4080, 0);
      add_req(4095, 4095, 4095, 4095);
      add_req(-1, -1, -1, -1);
      add_req(1, 2, 2, 1);
      add_req(100, -7, 3000, -200);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = pcts[ph];
         for (int n = 0; n < 500; n++) begin
            r.bx = rand_grad(); r.by = rand_grad();
            if ($urandom_range(0, 3) == 0) begin
               r.mx = r.bx; r.my = r.by;
            end else begin
               r.mx = rand_grad(); r.my = rand_grad();
            end
            pending_reqs.push_back(r);
            // Pause the sender midway until every cost has arrived.
            if (ph == 2 && n == 250) begin
               while (pending_reqs.size() != 0 || start) @(posedge clock);
               hold_sender = 1'b1;
               while (expected_costs.size() != 0) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         wait_drained();
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && expected_costs.size() == 0) begin
         $display("gradient_orientation_cost_unit: match");
      end else begin
         $display("gradient_orientation_cost_unit: mismatch");
      end
      $finish;
   end
endmodule
